FILE: rtl/scbpi_pkg.sv
`default_nettype none

package scbpi_pkg;

	// field widths
	localparam int ACTION_W = 2;
	localparam int HALL_W = 3;
	localparam int DEMAND_W = 10;
	localparam int GAIN_W = 16;
	localparam int POLE_W = 4;
	localparam int SPEED_W = 24;
	localparam int SCALE_W = 8;
	localparam int DUTY_W = 11;
	localparam int OVR_W = 16;
	localparam int PERIOD_W = 16;
	localparam int INTEG_W = 32;
	localparam int TARGET_W = DEMAND_W + SCALE_W;
	localparam int ERR_W = SPEED_W + 2;
	localparam int PROD_W = GAIN_W + 1 + INTEG_W;
	localparam int DELTA_W = PROD_W + 1 - 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = SPEED_W;

	// divider iteration count, one quotient bit per cycle
	localparam int DIV_STEPS = SPEED_W;
	localparam int DIV_STEP_W = $clog2(DIV_STEPS);

	// action codes
	localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_HALL = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_PI = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POLE_PAIRS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_POS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_FACTOR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEMAND_SCALE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX = 3'd7;

	// register reset values
	localparam logic [GAIN_W-1:0] KP_RST = 16'd1311;
	localparam logic [GAIN_W-1:0] KI_RST = 16'd153;
	localparam logic [POLE_W-1:0] POLE_PAIRS_RST = 4'd2;
	localparam logic [HALL_W-1:0] INDEX_POS_RST = 3'd5;
	localparam logic [SPEED_W-1:0] SPEED_FACTOR_RST = 24'd2343750;
	localparam logic [SCALE_W-1:0] DEMAND_SCALE_RST = 8'd16;
	localparam logic [DUTY_W-1:0] DUTY_MIN_RST = 11'd5;
	localparam logic [DUTY_W-1:0] DUTY_MAX_RST = 11'd1024;
	localparam logic [DUTY_W-1:0] DUTY_RST = 11'd100;

	// six-step override patterns
	localparam logic [OVR_W-1:0] OVR_OFF = 16'h0000;
	localparam logic [OVR_W-1:0] OVR_A = 16'h0210;
	localparam logic [OVR_W-1:0] OVR_B = 16'h2004;
	localparam logic [OVR_W-1:0] OVR_C = 16'h0204;
	localparam logic [OVR_W-1:0] OVR_D = 16'h0801;
	localparam logic [OVR_W-1:0] OVR_E = 16'h0810;
	localparam logic [OVR_W-1:0] OVR_F = 16'h2001;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic div_step;
		logic err_en;
		logic sum_en;
		logic mul_p_en;
		logic mul_i_en;
		logic add_en;
		logic duty_en;
		logic load_out;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic avg_zero;
	} dp_stat_t;

	// commutation table lookup, invalid hall codes give all off
	function automatic logic [OVR_W-1:0] hall_override(input logic ccw,
		input logic [HALL_W-1:0] hall);
		logic [OVR_W-1:0] w;
		case ({ccw, hall})
			4'b0_001: w = OVR_A;
			4'b0_010: w = OVR_B;
			4'b0_011: w = OVR_C;
			4'b0_100: w = OVR_D;
			4'b0_101: w = OVR_E;
			4'b0_110: w = OVR_F;
			4'b1_001: w = OVR_F;
			4'b1_010: w = OVR_E;
			4'b1_011: w = OVR_D;
			4'b1_100: w = OVR_C;
			4'b1_101: w = OVR_B;
			4'b1_110: w = OVR_A;
			default: w = OVR_OFF;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/scbpi_ctrl.sv
`default_nettype none

module scbpi_ctrl (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [scbpi_pkg::ACTION_W-1:0]     in_action,
	input  wire logic                               in_brake,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	input  wire scbpi_pkg::dp_stat_t                stat,
	output scbpi_pkg::dp_cmd_t                      cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_ERR,
		S_SUM,
		S_MULP,
		S_MULI,
		S_ADD,
		S_DUTY,
		S_EMIT
	} state_t;

	state_t state_q;
	logic [scbpi_pkg::DIV_STEP_W-1:0] step_q;
	logic out_valid_q;
	logic accept;
	logic emit_go;
	logic pi_run;

	// handshake decode
	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && (state_q == S_IDLE);
	assign emit_go = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign pi_run = (in_action == scbpi_pkg::ACT_PI) && !in_brake;
	assign out_valid = out_valid_q;

	// datapath commands
	always_comb begin
		cmd = '0;
		cmd.accept = accept;
		cmd.div_step = (state_q == S_DIV);
		cmd.err_en = (state_q == S_ERR);
		cmd.sum_en = (state_q == S_SUM);
		cmd.mul_p_en = (state_q == S_MULP);
		cmd.mul_i_en = (state_q == S_MULI);
		cmd.add_en = (state_q == S_ADD);
		cmd.duty_en = (state_q == S_DUTY);
		cmd.load_out = emit_go;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q <= '0;
						if (pi_run) begin
							state_q <= stat.avg_zero ? S_ERR : S_DIV;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == scbpi_pkg::DIV_STEP_W'(scbpi_pkg::DIV_STEPS - 1)) begin
						state_q <= S_ERR;
					end
				end
				S_ERR: state_q <= S_SUM;
				S_SUM: state_q <= S_MULP;
				S_MULP: state_q <= S_MULI;
				S_MULI: state_q <= S_ADD;
				S_ADD: state_q <= S_DUTY;
				S_DUTY: state_q <= S_EMIT;
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a result only appears out of the emit step
	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result raised outside emit step");

	// items without a speed update go to the emit step on the next cycle
	a_short_item: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !pi_run) |=> (state_q == S_EMIT))
		else $error("short item did not go to emit");

	// divider runs its full count then hands over to the error step
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV &&
		 step_q == scbpi_pkg::DIV_STEP_W'(scbpi_pkg::DIV_STEPS - 1))
		|=> (state_q == S_ERR))
		else $error("divider did not finish on its last step");

endmodule

`default_nettype wire

FILE: rtl/scbpi_dp.sv
`default_nettype none

module scbpi_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire scbpi_pkg::dp_cmd_t                   cmd,
	output scbpi_pkg::dp_stat_t                       stat,
	input  wire logic                                 cfg_we,
	input  wire logic [scbpi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [scbpi_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic [scbpi_pkg::ACTION_W-1:0]       action,
	input  wire logic [scbpi_pkg::HALL_W-1:0]         hall_state,
	input  wire logic [scbpi_pkg::DEMAND_W-1:0]       demand,
	input  wire logic                                 direction,
	input  wire logic                                 brake,
	output logic [scbpi_pkg::OVR_W-1:0]               override_word,
	output logic                                      pwm_enable,
	output logic [scbpi_pkg::DUTY_W-1:0]              duty_out,
	output logic [scbpi_pkg::SPEED_W-1:0]             speed_rpm,
	output logic                                      rev_captured
);

	localparam int PW = scbpi_pkg::PERIOD_W;
	localparam int SW = scbpi_pkg::SPEED_W;
	localparam int DW = scbpi_pkg::DUTY_W;
	localparam int EW = scbpi_pkg::ERR_W;
	localparam int IW = scbpi_pkg::INTEG_W;
	localparam int XW = scbpi_pkg::PROD_W;
	localparam int LW = scbpi_pkg::DELTA_W;
	localparam int GW = scbpi_pkg::GAIN_W;
	localparam int TW = scbpi_pkg::TARGET_W;
	localparam int DSUM_W = LW + 1;

	// configuration registers
	logic [GW-1:0] kp_q, ki_q;
	logic [scbpi_pkg::POLE_W-1:0] pole_pairs_q;
	logic [scbpi_pkg::HALL_W-1:0] index_pos_q;
	logic [SW-1:0] speed_factor_q;
	logic [scbpi_pkg::SCALE_W-1:0] demand_scale_q;
	logic [DW-1:0] duty_min_q, duty_max_q;

	// block state
	logic [PW-1:0] period_q, avg_q;
	logic [scbpi_pkg::POLE_W-1:0] pole_cnt_q;
	logic signed [IW-1:0] integ_q;
	logic [DW-1:0] duty_q;
	logic [scbpi_pkg::OVR_W-1:0] last_ovr_q;
	logic [SW-1:0] last_speed_q;
	logic captured_q, brake_q;

	// working registers
	logic [PW-1:0] rem_q;
	logic [SW-1:0] quo_q;
	logic [TW-1:0] target_q;
	logic signed [EW-1:0] err_q;
	logic signed [IW-1:0] sum_q;
	logic signed [XW-1:0] prod_p_q, prod_i_q;
	logic signed [LW-1:0] delta_q;

	// output register
	logic [scbpi_pkg::OVR_W-1:0] ovr_out_q;
	logic pwm_out_q, cap_out_q;
	logic [DW-1:0] duty_out_q;
	logic [SW-1:0] speed_out_q;

	logic is_tick, is_hall, is_pi, hall_hit, pole_match;
	logic [PW:0] avg_sum;
	logic [PW:0] rem_sh;
	logic [PW+1:0] rem_diff;
	logic [SW-1:0] speed_now;
	logic signed [IW:0] sum_wide;
	logic signed [IW-1:0] sum_sat;
	logic signed [GW:0] mul_a;
	logic signed [IW-1:0] mul_b;
	logic signed [XW-1:0] mul_y;
	logic signed [XW:0] prod_sum;
	logic signed [DSUM_W-1:0] duty_wide, duty_lo, duty_fin, dmin_w, dmax_w;
	logic clamp_lo, clamp_hi;

	assign stat.avg_zero = (avg_q == '0);

	// item decode
	assign is_tick = cmd.accept && (action == scbpi_pkg::ACT_TICK);
	assign is_hall = cmd.accept && (action == scbpi_pkg::ACT_HALL);
	assign is_pi = cmd.accept && (action == scbpi_pkg::ACT_PI);
	assign hall_hit = (hall_state == index_pos_q);
	assign pole_match = (pole_cnt_q == pole_pairs_q);
	assign avg_sum = {1'b0, avg_q} + {1'b0, period_q};

	// restoring divider step
	assign rem_sh = {rem_q, quo_q[SW-1]};
	assign rem_diff = {1'b0, rem_sh} - {2'b00, avg_q};
	assign speed_now = stat.avg_zero ? '0 : quo_q;

	// integral accumulate with saturation
	assign sum_wide = {integ_q[IW-1], integ_q} + (IW+1)'(err_q);
	always_comb begin
		if (sum_wide[IW] != sum_wide[IW-1]) begin
			sum_sat = sum_wide[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[IW-1:0];
		end
	end

	// shared gain multiplier
	assign mul_a = cmd.mul_i_en ? $signed({1'b0, ki_q}) : $signed({1'b0, kp_q});
	assign mul_b = cmd.mul_i_en ? sum_q : IW'(err_q);
	assign mul_y = mul_a * mul_b;
	assign prod_sum = {prod_p_q[XW-1], prod_p_q} + {prod_i_q[XW-1], prod_i_q};

	// duty update, lower clamp then upper clamp
	assign dmin_w = $signed({{(DSUM_W-DW){1'b0}}, duty_min_q});
	assign dmax_w = $signed({{(DSUM_W-DW){1'b0}}, duty_max_q});
	assign duty_wide = $signed({{(DSUM_W-DW){1'b0}}, duty_q}) + {delta_q[LW-1], delta_q};
	assign clamp_lo = (duty_wide < dmin_w);
	assign duty_lo = clamp_lo ? dmin_w : duty_wide;
	assign clamp_hi = (duty_lo > dmax_w);
	assign duty_fin = clamp_hi ? dmax_w : duty_lo;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= scbpi_pkg::KP_RST;
			ki_q <= scbpi_pkg::KI_RST;
			pole_pairs_q <= scbpi_pkg::POLE_PAIRS_RST;
			index_pos_q <= scbpi_pkg::INDEX_POS_RST;
			speed_factor_q <= scbpi_pkg::SPEED_FACTOR_RST;
			demand_scale_q <= scbpi_pkg::DEMAND_SCALE_RST;
			duty_min_q <= scbpi_pkg::DUTY_MIN_RST;
			duty_max_q <= scbpi_pkg::DUTY_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				scbpi_pkg::REG_KP_GAIN: kp_q <= cfg_data[GW-1:0];
				scbpi_pkg::REG_KI_GAIN: ki_q <= cfg_data[GW-1:0];
				scbpi_pkg::REG_POLE_PAIRS: pole_pairs_q <= cfg_data[scbpi_pkg::POLE_W-1:0];
				scbpi_pkg::REG_INDEX_POS: index_pos_q <= cfg_data[scbpi_pkg::HALL_W-1:0];
				scbpi_pkg::REG_SPEED_FACTOR: speed_factor_q <= cfg_data[SW-1:0];
				scbpi_pkg::REG_DEMAND_SCALE: demand_scale_q <= cfg_data[scbpi_pkg::SCALE_W-1:0];
				scbpi_pkg::REG_DUTY_MIN: duty_min_q <= cfg_data[DW-1:0];
				scbpi_pkg::REG_DUTY_MAX: duty_max_q <= cfg_data[DW-1:0];
				default: ;
			endcase
		end
	end

	// period counting, commutation and capture, duty and integral
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			avg_q <= '0;
			pole_cnt_q <= 4'd1;
			integ_q <= '0;
			duty_q <= scbpi_pkg::DUTY_RST;
			last_ovr_q <= '0;
			last_speed_q <= '0;
			captured_q <= 1'b0;
			brake_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				brake_q <= brake;
				captured_q <= 1'b0;
			end
			if (is_tick) begin
				period_q <= period_q + 1'b1;
			end
			if (is_hall) begin
				last_ovr_q <= scbpi_pkg::hall_override(direction, hall_state);
				if (hall_hit) begin
					if (pole_match) begin
						avg_q <= avg_sum[PW:1];
						period_q <= '0;
						pole_cnt_q <= 4'd1;
						captured_q <= 1'b1;
					end else begin
						pole_cnt_q <= pole_cnt_q + 1'b1;
					end
				end
			end
			if (cmd.err_en) begin
				last_speed_q <= speed_now;
			end
			if (cmd.sum_en) begin
				integ_q <= sum_sat;
			end
			if (cmd.duty_en) begin
				duty_q <= duty_fin[DW-1:0];
				if (clamp_lo || clamp_hi) begin
					integ_q <= '0;
				end
			end
		end
	end

	// speed loop working registers
	always_ff @(posedge clk) begin
		if (is_pi) begin
			rem_q <= '0;
			quo_q <= speed_factor_q;
			target_q <= TW'(demand) * TW'(demand_scale_q);
		end
		if (cmd.div_step) begin
			if (!rem_diff[PW+1]) begin
				rem_q <= rem_diff[PW-1:0];
				quo_q <= {quo_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[PW-1:0];
				quo_q <= {quo_q[SW-2:0], 1'b0};
			end
		end
		if (cmd.err_en) begin
			err_q <= $signed({{(EW-TW){1'b0}}, target_q}) - $signed({2'b00, speed_now});
		end
		if (cmd.sum_en) begin
			sum_q <= sum_sat;
		end
		if (cmd.mul_p_en) begin
			prod_p_q <= mul_y;
		end
		if (cmd.mul_i_en) begin
			prod_i_q <= mul_y;
		end
		if (cmd.add_en) begin
			delta_q <= prod_sum[XW:16];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			ovr_out_q <= brake_q ? scbpi_pkg::OVR_OFF : last_ovr_q;
			pwm_out_q <= !brake_q;
			duty_out_q <= duty_q;
			speed_out_q <= last_speed_q;
			cap_out_q <= captured_q;
		end
	end

	assign override_word = ovr_out_q;
	assign pwm_enable = pwm_out_q;
	assign duty_out = duty_out_q;
	assign speed_rpm = speed_out_q;
	assign rev_captured = cap_out_q;

	// with ordered clamps the new duty lands inside them
	a_duty_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		($past(cmd.duty_en) && (duty_min_q <= duty_max_q) && $stable(duty_min_q)
		 && $stable(duty_max_q))
		|-> ((duty_q >= duty_min_q) && (duty_q <= duty_max_q)))
		else $error("duty outside clamp range after update");

endmodule

`default_nettype wire

FILE: rtl/sensored_bldc_commutation_speed_pi_top.sv
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-------------------------------------------
// in        | to block  | in_valid/in_stall  | action hall_state demand direction brake
// out       | from block| out_valid/out_stall| override_word pwm_enable duty_out
//           |           |                    | speed_rpm rev_captured
// cfg       | to block  | cfg_we             | cfg_index cfg_data
//
// ticks, hall samples, unused actions and braked speed updates go straight to emit;
// a speed update runs the bit-serial speed divider, skipped with a zero average period,
// then the error, sum, products, add and duty steps; one request is worked on at a time.
// arst_n clears control and block state and loads register defaults; no clearing pass.
// a stalled result holds the output register; the next request is taken while it waits.
`default_nettype none

module sensored_bldc_commutation_speed_pi_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [scbpi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [scbpi_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [scbpi_pkg::ACTION_W-1:0]       action,
	input  wire logic [scbpi_pkg::HALL_W-1:0]         hall_state,
	input  wire logic [scbpi_pkg::DEMAND_W-1:0]       demand,
	input  wire logic                                 direction,
	input  wire logic                                 brake,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [scbpi_pkg::OVR_W-1:0]               override_word,
	output logic                                      pwm_enable,
	output logic [scbpi_pkg::DUTY_W-1:0]              duty_out,
	output logic [scbpi_pkg::SPEED_W-1:0]             speed_rpm,
	output logic                                      rev_captured
);

	scbpi_pkg::dp_cmd_t cmd;
	scbpi_pkg::dp_stat_t stat;

	// sequencer
	scbpi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_action (action),
		.in_brake  (brake),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath
	scbpi_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.action        (action),
		.hall_state    (hall_state),
		.demand        (demand),
		.direction     (direction),
		.brake         (brake),
		.override_word (override_word),
		.pwm_enable    (pwm_enable),
		.duty_out      (duty_out),
		.speed_rpm     (speed_rpm),
		.rev_captured  (rev_captured)
	);

endmodule

`default_nettype wire

FILE: bench/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import scbpi_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam longint INTEG_MAX = 64'sd2147483647;
	localparam longint INTEG_MIN = -64'sd2147483648;
	localparam int MAX_REPORTS = 10;
	localparam int SETTLE_CYCLES = 4;
	localparam int END_CYCLES = 40;
	localparam int CYCLE_LIMIT = 500000;

	// one bridge status as the block reports it
	typedef struct packed {
		logic [OVR_W-1:0]   ovr;
		logic               pwm;
		logic [DUTY_W-1:0]  duty;
		logic [SPEED_W-1:0] speed;
		logic               rev;
	} bridge_status_t;

	// commutation and speed loop predictor with its queue of bridge status
	class commutation_scoreboard;
		logic [GAIN_W-1:0]   kp_gain, ki_gain;
		logic [POLE_W-1:0]   pole_pairs;
		logic [HALL_W-1:0]   index_pos;
		logic [SPEED_W-1:0]  speed_factor;
		logic [SCALE_W-1:0]  demand_scale;
		logic [DUTY_W-1:0]   duty_min, duty_max;

		logic [PERIOD_W-1:0] period_count, avg_period;
		logic [POLE_W-1:0]   index_hits;
		int                  integ;
		logic [DUTY_W-1:0]   duty_level;
		logic [OVR_W-1:0]    bridge_word;
		logic [SPEED_W-1:0]  speed_now;

		bridge_status_t      pending_q[$];
		int unsigned         requests, results, failures;
		int unsigned         captures, speed_updates, saturations, settings;

		function new();
			kp_gain = KP_RST;
			ki_gain = KI_RST;
			pole_pairs = POLE_PAIRS_RST;
			index_pos = INDEX_POS_RST;
			speed_factor = SPEED_FACTOR_RST;
			demand_scale = DEMAND_SCALE_RST;
			duty_min = DUTY_MIN_RST;
			duty_max = DUTY_MAX_RST;
			period_count = '0;
			avg_period = '0;
			index_hits = POLE_W'(1);
			integ = 0;
			duty_level = DUTY_RST;
			bridge_word = OVR_OFF;
			speed_now = '0;
			requests = 0;
			results = 0;
			failures = 0;
			captures = 0;
			speed_updates = 0;
			saturations = 0;
			settings = 1;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_KP_GAIN:      kp_gain = data[GAIN_W-1:0];
				REG_KI_GAIN:      ki_gain = data[GAIN_W-1:0];
				REG_POLE_PAIRS:   pole_pairs = data[POLE_W-1:0];
				REG_INDEX_POS:    index_pos = data[HALL_W-1:0];
				REG_SPEED_FACTOR: speed_factor = data[SPEED_W-1:0];
				REG_DEMAND_SCALE: demand_scale = data[SCALE_W-1:0];
				REG_DUTY_MIN:     duty_min = data[DUTY_W-1:0];
				REG_DUTY_MAX:     duty_max = data[DUTY_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_request(input logic [ACTION_W-1:0] act,
			input logic [HALL_W-1:0] hall, input logic [DEMAND_W-1:0] dem,
			input logic ccw, input logic brk);
			logic [HALL_W-1:0]   slot;
			logic [POLE_W-1:0]   hits_seen;
			logic [PERIOD_W:0]   period_sum;
			logic                captured;
			longint              err, total, duty_step, duty_next;
			bridge_status_t      want;
			captured = 1'b0;
			requests++;
			case (act)
				ACT_TICK: period_count = period_count + PERIOD_W'(1);
				ACT_HALL: begin
					// anticlockwise table is the clockwise one read backwards
					slot = ccw ? ~hall : hall;
					case (slot)
						3'd1:    bridge_word = OVR_A;
						3'd2:    bridge_word = OVR_B;
						3'd3:    bridge_word = OVR_C;
						3'd4:    bridge_word = OVR_D;
						3'd5:    bridge_word = OVR_E;
						3'd6:    bridge_word = OVR_F;
						default: bridge_word = OVR_OFF;
					endcase
					// index pass counting, compared before the increment
					if (hall == index_pos) begin
						hits_seen = index_hits;
						index_hits = index_hits + POLE_W'(1);
						if (hits_seen == pole_pairs) begin
							period_sum = {1'b0, avg_period} + {1'b0, period_count};
							avg_period = period_sum[PERIOD_W:1];
							period_count = '0;
							index_hits = POLE_W'(1);
							captured = 1'b1;
							captures++;
						end
					end
				end
				ACT_PI: if (!brk) begin
					// speed from the average period, zero period gives zero
					if (avg_period == '0)
						speed_now = '0;
					else
						speed_now = speed_factor / SPEED_W'(avg_period);
					err = longint'(dem) * longint'(demand_scale) - longint'(speed_now);
					// saturating integral
					total = longint'(integ) + err;
					if (total > INTEG_MAX) begin
						total = INTEG_MAX;
						saturations++;
					end
					if (total < INTEG_MIN) begin
						total = INTEG_MIN;
						saturations++;
					end
					integ = int'(total);
					// q16 pi step, then lower and upper clamp in that order
					duty_step = (longint'(kp_gain) * err + longint'(ki_gain) * total) >>> 16;
					duty_next = longint'(duty_level) + duty_step;
					if (duty_next < longint'(duty_min)) begin
						duty_next = longint'(duty_min);
						integ = 0;
					end
					if (duty_next > longint'(duty_max)) begin
						duty_next = longint'(duty_max);
						integ = 0;
					end
					duty_level = duty_next[DUTY_W-1:0];
					speed_updates++;
				end
				default: ;
			endcase
			want.ovr = brk ? OVR_OFF : bridge_word;
			want.pwm = !brk;
			want.duty = duty_level;
			want.speed = speed_now;
			want.rev = captured;
			pending_q.push_back(want);
		endfunction

		function void check_result(input logic [OVR_W-1:0] ovr, input logic pwm,
			input logic [DUTY_W-1:0] duty, input logic [SPEED_W-1:0] speed,
			input logic rev);
			bridge_status_t want;
			results++;
			if (pending_q.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("result %0d arrived with no request waiting", results);
				return;
			end
			want = pending_q.pop_front();
			if (want.ovr !== ovr || want.pwm !== pwm || want.duty !== duty ||
				want.speed !== speed || want.rev !== rev) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("result %0d exp/got: ovr %h/%h pwm %b/%b duty %0d/%0d",
						results, want.ovr, ovr, want.pwm, pwm, want.duty, duty,
						" speed %0d/%0d rev %b/%b", want.speed, speed, want.rev, rev);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [ACTION_W-1:0]   action = ACT_TICK;
	logic [HALL_W-1:0]     hall_state = '0;
	logic [DEMAND_W-1:0]   demand = '0;
	logic                  direction = 1'b0;
	logic                  brake = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [OVR_W-1:0]      override_word;
	logic                  pwm_enable;
	logic [DUTY_W-1:0]     duty_out;
	logic [SPEED_W-1:0]    speed_rpm;
	logic                  rev_captured;

	commutation_scoreboard sb;
	int                    idle_pct = 0;
	int                    stall_pct = 0;
	int                    rotor_slot = 0;
	logic                  rotor_ccw = 1'b0;
	int unsigned           cycle_count = 0;

	sensored_bldc_commutation_speed_pi_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.hall_state(hall_state),
		.demand(demand),
		.direction(direction),
		.brake(brake),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.override_word(override_word),
		.pwm_enable(pwm_enable),
		.duty_out(duty_out),
		.speed_rpm(speed_rpm),
		.rev_captured(rev_captured)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver stall
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(override_word, pwm_enable, duty_out, speed_rpm, rev_captured);
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("CHECKS FAILED");
		$finish;
	end

	// one request, with random sender gaps ahead of it
	task automatic send_request(input logic [ACTION_W-1:0] act,
		input logic [HALL_W-1:0] hall, input logic [DEMAND_W-1:0] dem,
		input logic ccw, input logic brk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		hall_state <= hall;
		demand <= dem;
		direction <= ccw;
		brake <= brk;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(act, hall, dem, ccw, brk);
		@(negedge clk);
	endtask

	// hold off new requests until every result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_one(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		sb.write_reg(idx, data);
	endtask

	// program all registers while the block is idle
	task automatic apply_setting(input logic [CFG_DATA_W-1:0] kp, ki, pp, ipos,
		sf, scale, dmin, dmax);
		drain_results();
		write_one(REG_KP_GAIN, kp);
		write_one(REG_KI_GAIN, ki);
		write_one(REG_POLE_PAIRS, pp);
		write_one(REG_INDEX_POS, ipos);
		write_one(REG_SPEED_FACTOR, sf);
		write_one(REG_DEMAND_SCALE, scale);
		write_one(REG_DUTY_MIN, dmin);
		write_one(REG_DUTY_MAX, dmax);
		cfg_we <= 1'b0;
		sb.settings++;
	endtask

	// random requests: mostly a commutating motor, the rest noise
	task automatic run_phase(input int n_items, input int snd_idle, input int rcv_stall,
		input int drain_every);
		logic [ACTION_W-1:0] act;
		logic [HALL_W-1:0]   hall;
		logic [DEMAND_W-1:0] dem;
		logic                ccw, brk;
		int unsigned         pick;
		idle_pct = snd_idle;
		stall_pct = rcv_stall;
		for (int i = 0; i < n_items; i++) begin
			if (drain_every != 0 && i != 0 && i % drain_every == 0)
				drain_results();
			dem = DEMAND_W'($urandom_range(1023));
			if ($urandom_range(99) < 80) begin
				// ticks between hall edges, an occasional speed update
				pick = $urandom_range(99);
				brk = ($urandom_range(99) < 5);
				ccw = rotor_ccw;
				if (pick < 55) begin
					act = ACT_TICK;
				end else if (pick < 85) begin
					act = ACT_HALL;
					rotor_slot = rotor_ccw ? (rotor_slot + 5) % 6 : (rotor_slot + 1) % 6;
				end else begin
					act = ACT_PI;
				end
				hall = HALL_W'(rotor_slot + 1);
				if ($urandom_range(99) < 3)
					rotor_ccw = !rotor_ccw;
			end else begin
				// any code in every field
				act = ACTION_W'($urandom_range(3));
				hall = HALL_W'($urandom_range(7));
				ccw = 1'($urandom_range(1));
				brk = 1'($urandom_range(1));
			end
			send_request(act, hall, dem, ccw, brk);
		end
	endtask

	// stimulus
	initial begin
		sb = new();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed requests at register defaults
		send_request(ACT_PI, HALL_W'(0), DEMAND_W'(1023), 1'b0, 1'b0);
		send_request(ACT_UNUSED, HALL_W'(7), DEMAND_W'(1023), 1'b1, 1'b0);
		repeat (3) send_request(ACT_TICK, HALL_W'(0), DEMAND_W'(0), 1'b0, 1'b0);
		send_request(ACT_TICK, HALL_W'(2), DEMAND_W'(0), 1'b0, 1'b1);
		for (int h = 0; h < 8; h++)
			send_request(ACT_HALL, HALL_W'(h), DEMAND_W'($urandom_range(1023)), 1'b0, 1'b0);
		for (int h = 0; h < 8; h++)
			send_request(ACT_HALL, HALL_W'(h), DEMAND_W'($urandom_range(1023)), 1'b1, 1'b0);
		send_request(ACT_HALL, INDEX_POS_RST, DEMAND_W'(0), 1'b0, 1'b1);
		send_request(ACT_PI, HALL_W'(0), DEMAND_W'(512), 1'b0, 1'b1);
		send_request(ACT_PI, HALL_W'(0), DEMAND_W'(0), 1'b0, 1'b0);
		send_request(ACT_PI, HALL_W'(0), DEMAND_W'(1023), 1'b0, 1'b0);

		// moderate gains, capture on every index pass, no idling
		apply_setting(24'd4000, 24'd300, 24'd1, 24'd1, 24'd2343750, 24'd255, 24'd0, 24'd1024);
		run_phase(30, 0, 0, 0);

		// gains and pole count at their top, sender mostly idle
		apply_setting(24'd65535, 24'd65535, 24'd15, 24'd6, 24'd1, 24'd1, 24'd1024, 24'd1024);
		run_phase(30, 77, 0, 0);

		// crossed clamps, pole count that matches only after wrapping, receiver mostly stalled
		apply_setting(CFG_DATA_W'($urandom_range(65535)), CFG_DATA_W'($urandom_range(65535)),
			24'd0, 24'd7, CFG_DATA_W'($urandom_range(24'hFFFFFF, 1)),
			CFG_DATA_W'($urandom_range(255, 1)), 24'd900, 24'd100);
		stall_pct = 77;
		repeat (17) send_request(ACT_HALL, HALL_W'(7), DEMAND_W'(0), 1'b0, 1'b0);
		run_phase(30, 0, 77, 0);

		// raw register writes with junk above each register width, both sides idling
		apply_setting(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
			CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
			CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
		run_phase(30, 17, 17, 0);

		// average period forced to one, then the integral driven to its negative bound
		apply_setting(24'd0, 24'd0, 24'd1, 24'd3, 24'hFFFFFF, 24'd1, 24'd0, 24'd2047);
		idle_pct = 17;
		stall_pct = 17;
		for (int i = 0; i < 36; i++) begin
			send_request(ACT_TICK, HALL_W'(0), DEMAND_W'(0), 1'b0, 1'b0);
			send_request(ACT_HALL, HALL_W'(3), DEMAND_W'(0), 1'b0, 1'b0);
		end
		repeat (140) send_request(ACT_PI, HALL_W'(3), DEMAND_W'($urandom_range(1023)),
			1'b0, 1'b0);

		// saturated integral meets real gains, sender drains every twenty requests
		apply_setting(24'd1311, 24'd153, 24'd3, 24'd2, 24'd2343750, 24'd16, 24'd5, 24'd1024);
		run_phase(30, 0, 0, 20);

		drain_results();
		repeat (END_CYCLES) @(negedge clk);

		$display("covered %0d requests over %0d register settings, %0d results checked",
			sb.requests, sb.settings, sb.results);
		$display("%0d period captures, %0d speed updates, %0d integral saturations, %0d left",
			sb.captures, sb.speed_updates, sb.saturations, sb.pending_q.size());
		if (sb.failures == 0 && sb.pending_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
